/* hw/rtl/ssrl_pkg.sv */
// ----------------------------------------------------------------------------
// ssrl_pkg: shared types and constants of the soft-start ramp limiter
// Field widths, register indexes, reset values, microcode word layout.
// ----------------------------------------------------------------------------
package ssrl_pkg;

   localparam int NUM_WHEELS  = 4;
   localparam int WHEEL_IDX_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

   localparam int PWM_W     = 15;              // signed wheel command
   localparam int LIM_W     = 14;              // limit / config magnitudes
   localparam int MAG_W     = PWM_W;           // |command| reaches 16384
   localparam int PROD_W    = MAG_W + LIM_W;   // |command| * limit
   localparam int DIV_STEPS = LIM_W;           // quotient never above limit
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef logic signed [PWM_W-1:0] pwm_type;
   typedef logic [LIM_W-1:0]        lim_type;
   typedef logic [MAG_W-1:0]        mag_type;

   // configuration port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_ENABLE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DUTY      = 3'd3;

   localparam logic    RAMP_ENABLE_RST   = 1'b1;
   localparam lim_type INITIAL_LIMIT_RST = 14'd1000;
   localparam lim_type RAMP_STEP_RST     = 14'd100;
   localparam lim_type MAX_DUTY_RST      = 14'd10000;

   typedef struct packed {
      logic    ramp_enable;
      lim_type initial_limit;
      lim_type ramp_step;
      lim_type max_duty;
   } cfg_type;

   // microcode
   typedef logic [3:0] step_type;

   localparam step_type ST_IDLE     = 4'd0;
   localparam step_type ST_CHECK    = 4'd1;
   localparam step_type ST_MAX      = 4'd2;
   localparam step_type ST_TEST     = 4'd3;
   localparam step_type ST_DIV_LOAD = 4'd4;
   localparam step_type ST_DIV_RUN  = 4'd5;
   localparam step_type ST_DIV_DONE = 4'd6;
   localparam step_type ST_RAMP     = 4'd7;
   localparam step_type ST_OUT      = 4'd8;
   localparam step_type ST_STOP     = 4'd9;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_MAX_INIT,
      OP_MAX_STEP,
      OP_DIV_INIT,
      OP_DIV_START,
      OP_DIV_ITER,
      OP_DIV_STORE,
      OP_RAMP,
      OP_LOAD_OUT,
      OP_STOP
   } op_type;

   typedef enum logic [2:0] {
      CND_NEXT,
      CND_ALWAYS,
      CND_NO_REQ,
      CND_STOP,
      CND_IDX_MORE,
      CND_NO_SCALE,
      CND_DIV_MORE,
      CND_OUT_BUSY
   } cond_type;

   // cond true: jump to target; else done ? idle : next step
   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
      logic     done;
   } ctrl_type;

   typedef struct packed {
      logic action;
      logic idx_more;
      logic no_scale;
      logic div_more;
      logic out_busy;
   } stat_type;

endpackage

/* hw/rtl/ssrl_ucode_rom.sv */
// ----------------------------------------------------------------------------
// ssrl_ucode_rom: microprogram of the ramp limiter
// One control word per step: datapath op, jump condition, jump target.
// ----------------------------------------------------------------------------
module ssrl_ucode_rom import ssrl_pkg::*; (
   input  step_type pc,
   output ctrl_type ctrl
);

   always_comb begin
      case (pc)
         ST_IDLE:     ctrl = '{OP_NOP,       CND_NO_REQ,   ST_IDLE,     1'b0};
         ST_CHECK:    ctrl = '{OP_MAX_INIT,  CND_STOP,     ST_STOP,     1'b0};
         ST_MAX:      ctrl = '{OP_MAX_STEP,  CND_IDX_MORE, ST_MAX,      1'b0};
         ST_TEST:     ctrl = '{OP_DIV_INIT,  CND_NO_SCALE, ST_RAMP,     1'b0};
         ST_DIV_LOAD: ctrl = '{OP_DIV_START, CND_NEXT,     ST_IDLE,     1'b0};
         ST_DIV_RUN:  ctrl = '{OP_DIV_ITER,  CND_DIV_MORE, ST_DIV_RUN,  1'b0};
         ST_DIV_DONE: ctrl = '{OP_DIV_STORE, CND_IDX_MORE, ST_DIV_LOAD, 1'b0};
         ST_RAMP:     ctrl = '{OP_RAMP,      CND_NEXT,     ST_IDLE,     1'b0};
         ST_OUT:      ctrl = '{OP_LOAD_OUT,  CND_OUT_BUSY, ST_OUT,      1'b1};
         ST_STOP:     ctrl = '{OP_STOP,      CND_ALWAYS,   ST_OUT,      1'b0};
         default:     ctrl = '{OP_NOP,       CND_ALWAYS,   ST_IDLE,     1'b0};
      endcase
   end

endmodule

/* hw/rtl/ssrl_sequencer.sv */
// ----------------------------------------------------------------------------
// ssrl_sequencer: step counter with conditional jumps
// Evaluates the control word's condition against datapath status.
// ----------------------------------------------------------------------------
module ssrl_sequencer import ssrl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  ctrl_type ctrl,
   input  stat_type stat,
   output step_type pc
);

   step_type pc_ff, pc_in;
   logic     take;

   always_comb begin
      case (ctrl.cond)
         CND_NEXT:     take = 1'b0;
         CND_ALWAYS:   take = 1'b1;
         CND_NO_REQ:   take = !req_valid;
         CND_STOP:     take = stat.action;
         CND_IDX_MORE: take = stat.idx_more;
         CND_NO_SCALE: take = stat.no_scale;
         CND_DIV_MORE: take = stat.div_more;
         CND_OUT_BUSY: take = stat.out_busy;
         default:      take = 1'b0;
      endcase
   end

   always_comb begin
      if (take) begin
         pc_in = ctrl.target;
      end else if (ctrl.done) begin
         pc_in = ST_IDLE;
      end else begin
         pc_in = pc_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign pc = pc_ff;

endmodule

/* hw/rtl/ssrl_datapath.sv */
// ----------------------------------------------------------------------------
// ssrl_datapath: command registers, max search, bit-serial divider, ramp
// Driven by one microcode op per cycle; holds the result register.
// ----------------------------------------------------------------------------
module ssrl_datapath import ssrl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  ctrl_type ctrl,
   input  cfg_type  cfg,
   input  logic     req_fire,
   input  logic     req_action,
   input  pwm_type  req_pwm [NUM_WHEELS],
   input  logic     rsp_stall,
   output stat_type stat,
   output logic     rsp_valid,
   output pwm_type  rsp_pwm [NUM_WHEELS],
   output logic     rsp_scaled
);

   logic                   action_ff, action_in;
   pwm_type                pwm_ff [NUM_WHEELS];
   pwm_type                pwm_in [NUM_WHEELS];
   logic [WHEEL_IDX_W-1:0] idx_ff, idx_in;
   mag_type                max_ff, max_in;
   mag_type                rem_ff, rem_in;
   lim_type                quo_ff, quo_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   scaled_ff, scaled_in;
   lim_type                limit_ff, limit_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   pwm_type                out_pwm_ff [NUM_WHEELS];
   pwm_type                out_pwm_in [NUM_WHEELS];
   logic                   out_scaled_ff, out_scaled_in;

   pwm_type                cur_pwm;
   logic                   cur_neg;
   mag_type                cur_mag;
   logic [PROD_W-1:0]      prod;
   logic [MAG_W:0]         shifted;
   logic [MAG_W:0]         diff;
   logic                   ge;
   pwm_type                q_pwm;
   logic [LIM_W:0]         ramp_sum;
   logic                   any_nz;
   logic                   out_busy;
   logic                   load_out;

   // current wheel under the shared max / divide unit
   assign cur_pwm = pwm_ff[idx_ff];
   assign cur_neg = cur_pwm[PWM_W-1];
   assign cur_mag = cur_neg ? (~mag_type'(cur_pwm) + mag_type'(1)) : mag_type'(cur_pwm);
   assign prod    = PROD_W'(cur_mag) * PROD_W'(limit_ff);

   // restoring divide step, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[LIM_W-1]};
   assign diff    = shifted - {1'b0, max_ff};
   assign ge      = shifted >= {1'b0, max_ff};
   assign q_pwm   = pwm_type'({1'b0, quo_ff});

   assign ramp_sum = {1'b0, limit_ff} + {1'b0, cfg.ramp_step};

   always_comb begin
      any_nz = 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         any_nz = any_nz | (pwm_ff[i] != '0);
      end
   end

   assign out_busy = rsp_valid_ff && rsp_stall;
   assign load_out = (ctrl.op == OP_LOAD_OUT) && !out_busy;

   assign stat.action   = action_ff;
   assign stat.idx_more = idx_ff != WHEEL_IDX_W'(NUM_WHEELS - 1);
   assign stat.no_scale = !cfg.ramp_enable || (limit_ff == '0) ||
                          (max_ff <= mag_type'(limit_ff));
   assign stat.div_more = cnt_ff != CNT_W'(DIV_STEPS - 1);
   assign stat.out_busy = out_busy;

   always_comb begin
      action_in = action_ff;
      pwm_in    = pwm_ff;
      idx_in    = idx_ff;
      max_in    = max_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      scaled_in = scaled_ff;
      limit_in  = limit_ff;

      if (req_fire) begin
         action_in = req_action;
         pwm_in    = req_pwm;
         scaled_in = 1'b0;
      end

      case (ctrl.op)
         OP_NOP, OP_LOAD_OUT: begin
         end
         OP_MAX_INIT: begin
            idx_in = '0;
            max_in = '0;
         end
         OP_MAX_STEP: begin
            if (cur_mag > max_ff) begin
               max_in = cur_mag;
            end
            idx_in = idx_ff + 1'b1;
         end
         OP_DIV_INIT: begin
            idx_in = '0;
         end
         OP_DIV_START: begin
            // top bits already below the divisor: quotient fits LIM_W bits
            rem_in = prod[PROD_W-1 -: MAG_W];
            quo_in = prod[LIM_W-1:0];
            cnt_in = '0;
         end
         OP_DIV_ITER: begin
            rem_in = ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
            quo_in = {quo_ff[LIM_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
         end
         OP_DIV_STORE: begin
            pwm_in[idx_ff] = cur_neg ? -q_pwm : q_pwm;
            scaled_in      = 1'b1;
            idx_in         = idx_ff + 1'b1;
         end
         OP_RAMP: begin
            if (cfg.ramp_enable) begin
               if (!any_nz) begin
                  limit_in = cfg.initial_limit;
               end else if (limit_ff < cfg.max_duty) begin
                  limit_in = (ramp_sum > {1'b0, cfg.max_duty}) ? cfg.max_duty
                                                               : ramp_sum[LIM_W-1:0];
               end
            end
         end
         OP_STOP: begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
               pwm_in[i] = '0;
            end
            scaled_in = 1'b0;
            limit_in  = cfg.initial_limit;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_pwm_in    = out_pwm_ff;
      out_scaled_in = out_scaled_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         out_pwm_in    = pwm_ff;
         out_scaled_in = scaled_ff;
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= INITIAL_LIMIT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      pwm_ff        <= pwm_in;
      idx_ff        <= idx_in;
      max_ff        <= max_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      scaled_ff     <= scaled_in;
      out_pwm_ff    <= out_pwm_in;
      out_scaled_ff <= out_scaled_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pwm    = out_pwm_ff;
   assign rsp_scaled = out_scaled_ff;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_DIV_ITER) |-> (rem_ff < max_ff))
      else $error("divider remainder not below divisor");

   a_quotient_within_limit: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_DIV_STORE) |-> (quo_ff <= limit_ff))
      else $error("scaled magnitude above ramp limit");

   a_scaled_needs_enable: assert property (@(posedge clock) disable iff (reset)
      (load_out && scaled_ff) |-> cfg.ramp_enable)
      else $error("scaled result with limiting disabled");

   a_stop_skips_search: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_MAX_STEP) |-> !action_ff)
      else $error("max search entered on a stop request");
`endif

endmodule

/* hw/rtl/soft_start_pwm_ramp_limiter_unit.sv */
// ----------------------------------------------------------------------------
// soft_start_pwm_ramp_limiter_unit: soft-start ramp limiter for wheel PWM
// Path: max search over all wheels, then one divide per wheel when scaling;
//   a stop skips both, zeroes the commands and resets the ramp limit.
// Throughput: one request at a time; the shared bit-serial divider (one
//   quotient bit per cycle, per wheel) sets the scaling case.
// The next request is taken as soon as the result is in the output register.
// Reset: sync, active high; config regs to defaults, ramp limit to 1000.
// ----------------------------------------------------------------------------
module soft_start_pwm_ramp_limiter_unit import ssrl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  pwm_type              req_wheel_pwm_0,
   input  pwm_type              req_wheel_pwm_1,
   input  pwm_type              req_wheel_pwm_2,
   input  pwm_type              req_wheel_pwm_3,

   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pwm_type              rsp_out_pwm_0,
   output pwm_type              rsp_out_pwm_1,
   output pwm_type              rsp_out_pwm_2,
   output pwm_type              rsp_out_pwm_3,
   output logic                 rsp_was_scaled,

   // config write port
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  lim_type              csr_wdata
);

   // config registers
   logic     ramp_enable_ff,   ramp_enable_in;
   lim_type  initial_limit_ff, initial_limit_in;
   lim_type  ramp_step_ff,     ramp_step_in;
   lim_type  max_duty_ff,      max_duty_in;
   cfg_type  cfg;

   step_type pc;
   ctrl_type ctrl;
   stat_type stat;
   logic     req_fire;
   pwm_type  req_pwm [NUM_WHEELS];
   pwm_type  rsp_pwm [NUM_WHEELS];

   // writes land directly in the config registers, so the port is always ready
   assign csr_ready = 1'b1;

   always_comb begin
      ramp_enable_in   = ramp_enable_ff;
      initial_limit_in = initial_limit_ff;
      ramp_step_in     = ramp_step_ff;
      max_duty_in      = max_duty_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RAMP_ENABLE:   ramp_enable_in   = csr_wdata[0];
            CSR_INITIAL_LIMIT: initial_limit_in = csr_wdata;
            CSR_RAMP_STEP:     ramp_step_in     = csr_wdata;
            CSR_MAX_DUTY:      max_duty_in      = csr_wdata;
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_enable_ff   <= RAMP_ENABLE_RST;
         initial_limit_ff <= INITIAL_LIMIT_RST;
         ramp_step_ff     <= RAMP_STEP_RST;
         max_duty_ff      <= MAX_DUTY_RST;
      end else begin
         ramp_enable_ff   <= ramp_enable_in;
         initial_limit_ff <= initial_limit_in;
         ramp_step_ff     <= ramp_step_in;
         max_duty_ff      <= max_duty_in;
      end
   end

   assign cfg.ramp_enable   = ramp_enable_ff;
   assign cfg.initial_limit = initial_limit_ff;
   assign cfg.ramp_step     = ramp_step_ff;
   assign cfg.max_duty      = max_duty_ff;

   // request taken only while the sequencer sits in its idle step
   assign req_stall = (pc != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;

   assign req_pwm[0] = req_wheel_pwm_0;
   assign req_pwm[1] = req_wheel_pwm_1;
   assign req_pwm[2] = req_wheel_pwm_2;
   assign req_pwm[3] = req_wheel_pwm_3;

   ssrl_ucode_rom u_rom (
      .pc   (pc),
      .ctrl (ctrl)
   );

   ssrl_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .ctrl      (ctrl),
      .stat      (stat),
      .pc        (pc)
   );

   ssrl_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .cfg        (cfg),
      .req_fire   (req_fire),
      .req_action (req_action),
      .req_pwm    (req_pwm),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_pwm    (rsp_pwm),
      .rsp_scaled (rsp_was_scaled)
   );

   assign rsp_out_pwm_0 = rsp_pwm[0];
   assign rsp_out_pwm_1 = rsp_pwm[1];
   assign rsp_out_pwm_2 = rsp_pwm[2];
   assign rsp_out_pwm_3 = rsp_pwm[3];

endmodule

/* bench/ramp_limit_checker.sv */
// ----------------------------------------------------------------------------
// ramp_limit_checker: result predictor and scoreboard for the ramp limiter
// Tracks register writes and the ramp limit, predicts the limited commands for
// every accepted request and compares them in order with the accepted results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ramp_limit_checker import ssrl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_action,
   input  pwm_type              req_wheel_pwm_0,
   input  pwm_type              req_wheel_pwm_1,
   input  pwm_type              req_wheel_pwm_2,
   input  pwm_type              req_wheel_pwm_3,

   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  pwm_type              rsp_out_pwm_0,
   input  pwm_type              rsp_out_pwm_1,
   input  pwm_type              rsp_out_pwm_2,
   input  pwm_type              rsp_out_pwm_3,
   input  logic                 rsp_was_scaled,

   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  lim_type              csr_wdata,

   output int                   mismatches,
   output int                   outstanding,
   output int                   results_checked,
   output int                   results_scaled
);

   typedef logic [NUM_WHEELS-1:0][PWM_W-1:0] wheel_vec_type;

   typedef struct packed {
      logic          scaled;
      wheel_vec_type wheel;
   } limited_cmd_type;

   cfg_type         cfg;
   lim_type         ramp_lim;
   limited_cmd_type limited_q [$];
   int              n_bad;
   int              n_checked;
   int              n_scaled;

   // limit one set of wheel commands and advance the ramp
   function automatic limited_cmd_type limit_wheels(input logic stop,
                                                    input wheel_vec_type cmd_in);
      limited_cmd_type res;
      int              cmd [NUM_WHEELS];
      int              peak;
      int              mag;
      int              grown;
      bit              any;
      res  = '0;
      peak = 0;
      any  = 1'b0;
      if (stop) begin
         ramp_lim = cfg.initial_limit;
      end else begin
         for (int i = 0; i < NUM_WHEELS; i++)
            cmd[i] = $signed(cmd_in[i]);
         if (cfg.ramp_enable) begin
            if (ramp_lim != 0) begin
               for (int i = 0; i < NUM_WHEELS; i++) begin
                  mag = (cmd[i] < 0) ? -cmd[i] : cmd[i];
                  if (mag > peak)
                     peak = mag;
               end
               if (peak > int'(ramp_lim)) begin
                  res.scaled = 1'b1;
                  for (int i = 0; i < NUM_WHEELS; i++) begin
                     mag    = (cmd[i] < 0) ? -cmd[i] : cmd[i];
                     mag    = (mag * int'(ramp_lim)) / peak;
                     cmd[i] = (cmd[i] < 0) ? -mag : mag;
                  end
               end
            end
            for (int i = 0; i < NUM_WHEELS; i++)
               if (cmd[i] != 0)
                  any = 1'b1;
            if (!any) begin
               ramp_lim = cfg.initial_limit;
            end else if (ramp_lim < cfg.max_duty) begin
               grown = int'(ramp_lim) + int'(cfg.ramp_step);
               if (grown > int'(cfg.max_duty))
                  grown = int'(cfg.max_duty);
               ramp_lim = grown[LIM_W-1:0];
            end
         end
         for (int i = 0; i < NUM_WHEELS; i++)
            res.wheel[i] = cmd[i][PWM_W-1:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      limited_cmd_type want;
      wheel_vec_type   got;
      if (reset) begin
         cfg.ramp_enable   = RAMP_ENABLE_RST;
         cfg.initial_limit = INITIAL_LIMIT_RST;
         cfg.ramp_step     = RAMP_STEP_RST;
         cfg.max_duty      = MAX_DUTY_RST;
         ramp_lim          = INITIAL_LIMIT_RST;
         limited_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RAMP_ENABLE:   cfg.ramp_enable   = csr_wdata[0];
               CSR_INITIAL_LIMIT: cfg.initial_limit = csr_wdata;
               CSR_RAMP_STEP:     cfg.ramp_step     = csr_wdata;
               CSR_MAX_DUTY:      cfg.max_duty      = csr_wdata;
               default: ;
            endcase
         end

         // oldest expectation first, then any new request
         if (rsp_valid && !rsp_stall) begin
            if (limited_q.size() == 0) begin
               $error("result with no request pending: out_pwm %0d %0d %0d %0d, was_scaled %0d",
                      rsp_out_pwm_0, rsp_out_pwm_1, rsp_out_pwm_2, rsp_out_pwm_3,
                      rsp_was_scaled);
               n_bad++;
            end else begin
               want = limited_q.pop_front();
               got  = {rsp_out_pwm_3, rsp_out_pwm_2, rsp_out_pwm_1, rsp_out_pwm_0};
               for (int i = 0; i < NUM_WHEELS; i++)
                  if (got[i] !== want.wheel[i]) begin
                     $error("out_pwm_%0d: expected %0d, actual %0d", i,
                            $signed(want.wheel[i]), $signed(got[i]));
                     n_bad++;
                  end
               if (rsp_was_scaled !== want.scaled) begin
                  $error("was_scaled: expected %0d, actual %0d", want.scaled, rsp_was_scaled);
                  n_bad++;
               end
               n_checked++;
               if (want.scaled)
                  n_scaled++;
            end
         end

         if (req_valid && !req_stall)
            limited_q.push_back(limit_wheels(req_action,
               {req_wheel_pwm_3, req_wheel_pwm_2, req_wheel_pwm_1, req_wheel_pwm_0}));
      end
      mismatches      <= n_bad;
      outstanding     <= limited_q.size();
      results_checked <= n_checked;
      results_scaled  <= n_scaled;
   end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the soft-start PWM ramp limiter
// Directed requests on reset settings, pass-through and zero-limit corners,
// then random wheel commands over a series of register settings, with random
// request gaps and result stalls. A side checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top import ssrl_pkg::*; ();

   localparam int LIMIT_CYCLES   = 1000000;
   localparam int SETTLE_CYCLES  = 100;   // above the scaling latency
   localparam int RAND_PHASES    = 12;
   localparam int PHASE_REQUESTS = 105;

   localparam logic ACT_APPLY = 1'b0;
   localparam logic ACT_STOP  = 1'b1;

   // register indexes the block does not decode
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   // full-width command extremes
   localparam pwm_type PWM_TOP    = 15'h3FFF;
   localparam pwm_type PWM_BOTTOM = 15'h4000;
   localparam lim_type LIM_FULL   = 14'h3FFF;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_action = 1'b0;
   pwm_type              req_wheel_pwm_0 = '0;
   pwm_type              req_wheel_pwm_1 = '0;
   pwm_type              req_wheel_pwm_2 = '0;
   pwm_type              req_wheel_pwm_3 = '0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   pwm_type              rsp_out_pwm_0;
   pwm_type              rsp_out_pwm_1;
   pwm_type              rsp_out_pwm_2;
   pwm_type              rsp_out_pwm_3;
   logic                 rsp_was_scaled;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   lim_type              csr_wdata = '0;

   int mismatches;
   int outstanding;
   int results_checked;
   int results_scaled;

   bit idle_on = 1'b1;     // random gaps and stalls allowed
   int stall_left = 0;
   int cycles = 0;
   int requests_sent = 0;
   int settings_done = 0;

   always #5 clock = ~clock;

   soft_start_pwm_ramp_limiter_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_wheel_pwm_0 (req_wheel_pwm_0),
      .req_wheel_pwm_1 (req_wheel_pwm_1),
      .req_wheel_pwm_2 (req_wheel_pwm_2),
      .req_wheel_pwm_3 (req_wheel_pwm_3),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_pwm_0   (rsp_out_pwm_0),
      .rsp_out_pwm_1   (rsp_out_pwm_1),
      .rsp_out_pwm_2   (rsp_out_pwm_2),
      .rsp_out_pwm_3   (rsp_out_pwm_3),
      .rsp_was_scaled  (rsp_was_scaled),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   ramp_limit_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_wheel_pwm_0 (req_wheel_pwm_0),
      .req_wheel_pwm_1 (req_wheel_pwm_1),
      .req_wheel_pwm_2 (req_wheel_pwm_2),
      .req_wheel_pwm_3 (req_wheel_pwm_3),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_pwm_0   (rsp_out_pwm_0),
      .rsp_out_pwm_1   (rsp_out_pwm_1),
      .rsp_out_pwm_2   (rsp_out_pwm_2),
      .rsp_out_pwm_3   (rsp_out_pwm_3),
      .rsp_was_scaled  (rsp_was_scaled),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .results_scaled  (results_scaled)
   );

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results still pending", cycles, outstanding);
         $display("Mismatches found");
         $finish;
      end
   end

   // result-side back-pressure: stall bursts of random length
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // One request. Valid stays high from one request to the next unless a gap
   // is inserted, so back-to-back requests never see valid dropped and raised
   // in the same step. Returns at the edge where the request was taken.
   task automatic send_request(input logic act, input pwm_type w0, input pwm_type w1,
                               input pwm_type w2, input pwm_type w3);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_wheel_pwm_0 <= w0;
      req_wheel_pwm_1 <= w1;
      req_wheel_pwm_2 <= w2;
      req_wheel_pwm_3 <= w3;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   // drop valid and hold off until every result has been taken
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input lim_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // full register set, plus a write to an undecoded index that must be ignored
   task automatic program_regs(input logic en, input lim_type init, input lim_type step,
                               input lim_type duty);
      write_csr(CSR_RAMP_ENABLE, lim_type'(en));
      write_csr(CSR_INITIAL_LIMIT, init);
      write_csr(CSR_RAMP_STEP, step);
      write_csr(CSR_MAX_DUTY, duty);
      write_csr(CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)),
                lim_type'($urandom));
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   // mix of zero, extremes, small, in-range and raw 15-bit commands
   function automatic pwm_type random_wheel();
      pwm_type w;
      int      mag;
      w   = '0;
      mag = 0;
      case ($urandom_range(0, 9))
         0: w = '0;
         1: w = $urandom_range(0, 1) ? PWM_TOP : PWM_BOTTOM;
         2, 3: mag = $urandom_range(1, 2000);
         4, 5, 6: mag = $urandom_range(1, 10000);
         default: w = pwm_type'($urandom);
      endcase
      if (mag != 0)
         w = $urandom_range(0, 1) ? pwm_type'(-mag) : pwm_type'(mag);
      return w;
   endfunction

   task automatic send_random();
      pwm_type w [NUM_WHEELS];
      int      pick;
      int      keep;
      pick = $urandom_range(0, 99);
      keep = $urandom_range(0, NUM_WHEELS - 1);
      for (int i = 0; i < NUM_WHEELS; i++)
         w[i] = random_wheel();
      if (pick < 6) begin
         // stop: wheels carry noise and must be ignored
         send_request(ACT_STOP, w[0], w[1], w[2], w[3]);
      end else if (pick < 13) begin
         send_request(ACT_APPLY, '0, '0, '0, '0);
      end else if (pick < 22) begin
         // one wheel moving, the rest parked
         for (int i = 0; i < NUM_WHEELS; i++)
            if (i != keep)
               w[i] = '0;
         send_request(ACT_APPLY, w[0], w[1], w[2], w[3]);
      end else begin
         send_request(ACT_APPLY, w[0], w[1], w[2], w[3]);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset settings: limit 1000, step 100, ceiling 10000 ---
      send_request(ACT_STOP, PWM_TOP, PWM_BOTTOM, 15'sd5, -15'sd5);   // stop, noisy wheels
      send_request(ACT_APPLY, '0, '0, '0, '0);                       // all zero: limit back
      send_request(ACT_APPLY, 15'sd500, -15'sd500, '0, 15'sd999);    // under the limit
      send_request(ACT_APPLY, 15'sd1100, -15'sd1100, 15'sd1, -15'sd1); // exactly at limit
      send_request(ACT_APPLY, 15'sd2400, -15'sd1200, 15'sd600, -15'sd1); // scaled by half
      send_request(ACT_APPLY, PWM_TOP, PWM_BOTTOM, 15'sd1, -15'sd1);  // full-width peak
      send_request(ACT_APPLY, PWM_BOTTOM, '0, '0, '0);
      send_request(ACT_APPLY, 15'sd10000, -15'sd10000, 15'sd10000, -15'sd10000);
      send_request(ACT_APPLY, '0, '0, '0, 15'sd7);
      send_request(ACT_STOP, '0, '0, '0, '0);
      send_request(ACT_APPLY, PWM_TOP, PWM_TOP, PWM_TOP, PWM_TOP);
      wait_drained();

      // --- limiting off: commands pass, limit frozen; stop still resets ---
      program_regs(1'b0, INITIAL_LIMIT_RST, RAMP_STEP_RST, MAX_DUTY_RST);
      send_request(ACT_APPLY, PWM_BOTTOM, PWM_TOP, -15'sd1, '0);
      send_request(ACT_APPLY, '0, '0, '0, '0);
      send_request(ACT_STOP, 15'sd3000, '0, '0, '0);
      wait_drained();

      // --- lowest settings: zero initial limit, zero step, ceiling 1 ---
      program_regs(1'b1, '0, '0, 14'd1);
      send_request(ACT_STOP, '0, '0, '0, '0);                        // limit becomes 0
      send_request(ACT_APPLY, 15'sd5000, -15'sd3, '0, '0);           // zero limit: no scaling
      send_request(ACT_APPLY, PWM_BOTTOM, PWM_TOP, '0, '0);
      send_request(ACT_APPLY, '0, '0, '0, '0);
      wait_drained();

      // --- random phases, each under its own register setting ---
      for (int p = 0; p < RAND_PHASES; p++) begin
         // some phases run with no gaps or stalls at all, the last one too
         idle_on = (p % 4 != 2) && (p != RAND_PHASES - 1);
         case (p)
            0: program_regs(1'b1, 14'd10000, 14'd10000, 14'd10000);
            1: program_regs(1'b1, LIM_FULL, LIM_FULL, LIM_FULL);
            2: program_regs(1'b1, '0, 14'd1, 14'd10000);            // ramp up from zero
            3: program_regs(1'b0, lim_type'($urandom_range(0, 10000)),
                            lim_type'($urandom_range(0, 10000)),
                            lim_type'($urandom_range(1, 10000)));
            default: program_regs($urandom_range(0, 4) != 0,
                                  lim_type'($urandom_range(0, 10000)),
                                  lim_type'(($urandom_range(0, 3) == 0)
                                            ? $urandom_range(0, 10000)
                                            : $urandom_range(0, 500)),
                                  lim_type'($urandom_range(1, 10000)));
         endcase
         for (int n = 0; n < PHASE_REQUESTS; n++)
            send_random();
         // sender holds off here until the block has delivered everything
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d requests over %0d register settings plus reset values;",
               requests_sent, settings_done);
      $display("%0d results checked, %0d of them scaled by the ramp limit.",
               results_checked, results_scaled);
      if (mismatches == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
